@@ src/assert_macros.svh @@
// Assertion macros used by the checker module of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/imix_pkg.sv @@
// Types, constants and helpers for the instruction-mix performance counters.
// No dependencies; used by the top level and its checker.
`default_nettype none

package imix_pkg;

    localparam int CNT_W   = 32;
    localparam int FIELD_W = 32;
    localparam int NUM_CNT = 12;
    localparam int INSN_W  = 32;
    localparam int OPC_W   = 7;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = NUM_CNT * FIELD_W;

    typedef logic [CNT_W-1:0] t_cnt;

    // Counter slots, in output order.
    typedef enum logic [3:0] {
        CNT_CYCLE   = 4'd0,
        CNT_RETIRED = 4'd1,
        CNT_NOP     = 4'd2,
        CNT_BUBBLE  = 4'd3,
        CNT_ARITH   = 4'd4,
        CNT_BRANCH  = 4'd5,
        CNT_MISC    = 4'd6,
        CNT_LOAD    = 4'd7,
        CNT_STORE   = 4'd8,
        CNT_STALL   = 4'd9,
        CNT_RDMISS  = 4'd10,
        CNT_WRMISS  = 4'd11
    } t_cnt_sel;

    localparam logic [INSN_W-1:0] INSN_NOP    = 32'h0000_0013;
    localparam logic [INSN_W-1:0] INSN_BUBBLE = 32'h0000_4033;

    localparam logic [OPC_W-1:0] OPC_LUI    = 7'h37;
    localparam logic [OPC_W-1:0] OPC_BRANCH = 7'h63;
    localparam logic [OPC_W-1:0] OPC_LOAD   = 7'h03;
    localparam logic [OPC_W-1:0] OPC_STORE  = 7'h23;

    localparam logic [2:0] GRP_OP     = 3'h6;
    localparam logic [2:0] GRP_OP_IMM = 3'h4;

    // Saturating increment.
    function automatic t_cnt sat_inc(input t_cnt value);
        sat_inc = (&value) ? value : value + t_cnt'(1);
    endfunction

endpackage

`default_nettype wire

@@ src/instruction_mix_perf_counters.sv @@
// Instruction-mix performance counters: top level.
// A transferred sample waits in the input register and loads the counters when it advances.
// Throughput: one sample per cycle; the input register and the counter bank (the result
// register) form a two-stage pipeline, so a held result stalls the input once both are full.
// Reset (synchronous, active low) zeroes all counters and history and empties both stages.
// Depends on imix_pkg.
`default_nettype none

module instruction_mix_perf_counters (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // [31:0] instruction, [32] count_enable, [33] frozen, [39:34] zero
    input  wire logic [imix_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // [0] mode
    input  wire logic [0:0]                            i_s_axis_tuser,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // 32 bits each from bit 0 up: cycle_total, retired_total, nop_total,
    // bubble_total, arith_total, branch_total, misc_total, load_total,
    // store_total, miss_stall_total, read_miss_total, write_miss_total
    output logic [imix_pkg::OUT_TDATA_W-1:0]           o_m_axis_tdata
);

    logic                                r_in_valid;
    logic                                r_in_mode;
    logic [imix_pkg::INSN_W-1:0]         r_in_insn;
    logic                                r_in_cen;
    logic                                r_in_frz;

    logic                                r_out_valid;
    imix_pkg::t_cnt                      r_cnt [imix_pkg::NUM_CNT];
    logic                                r_prev_frozen;
    logic [imix_pkg::OPC_W-1:0]          r_prev_opcode;

    logic                                in_xfer;
    logic                                advance;
    logic [imix_pkg::NUM_CNT-1:0]        n_inc;
    logic [imix_pkg::OPC_W-1:0]          opcode;
    logic [2:0]                          grp;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;

    assign opcode = r_in_insn[imix_pkg::OPC_W-1:0];
    assign grp    = r_in_insn[4:2];

    // Which counters step for the sample held in the input register.
    always_comb begin
        n_inc = '0;
        n_inc[imix_pkg::CNT_CYCLE] = 1'b1;
        if (!r_in_frz) begin
            n_inc[imix_pkg::CNT_RETIRED] = r_in_cen && (r_in_insn != imix_pkg::INSN_BUBBLE);
            priority if (r_in_insn == imix_pkg::INSN_NOP) begin
                n_inc[imix_pkg::CNT_NOP] = 1'b1;
            end else if (r_in_insn == imix_pkg::INSN_BUBBLE) begin
                n_inc[imix_pkg::CNT_BUBBLE] = 1'b1;
            end else if (opcode == imix_pkg::OPC_LUI) begin
                n_inc[imix_pkg::CNT_MISC] = 1'b1;
            end else if (opcode == imix_pkg::OPC_BRANCH) begin
                n_inc[imix_pkg::CNT_BRANCH] = 1'b1;
            end else if (opcode == imix_pkg::OPC_LOAD) begin
                n_inc[imix_pkg::CNT_LOAD] = 1'b1;
            end else if (opcode == imix_pkg::OPC_STORE) begin
                n_inc[imix_pkg::CNT_STORE] = 1'b1;
            end else if (grp == imix_pkg::GRP_OP || grp == imix_pkg::GRP_OP_IMM) begin
                n_inc[imix_pkg::CNT_ARITH] = 1'b1;
            end else begin
                n_inc[imix_pkg::CNT_MISC] = 1'b1;
            end
        end else begin
            n_inc[imix_pkg::CNT_STALL] = 1'b1;
            // Only the onset of a freeze is charged to the access before it.
            if (!r_prev_frozen) begin
                n_inc[imix_pkg::CNT_RDMISS] = (r_prev_opcode == imix_pkg::OPC_LOAD);
                n_inc[imix_pkg::CNT_WRMISS] = (r_prev_opcode == imix_pkg::OPC_STORE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_mode <= i_s_axis_tuser[0];
            r_in_insn <= i_s_axis_tdata[imix_pkg::INSN_W-1:0];
            r_in_cen  <= i_s_axis_tdata[imix_pkg::INSN_W];
            r_in_frz  <= i_s_axis_tdata[imix_pkg::INSN_W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_prev_frozen <= 1'b0;
            r_prev_opcode <= '0;
            for (int i = 0; i < imix_pkg::NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (r_in_mode) begin
                    // Clear leaves the freeze history untouched.
                    for (int i = 0; i < imix_pkg::NUM_CNT; i++) begin
                        r_cnt[i] <= '0;
                    end
                end else begin
                    for (int i = 0; i < imix_pkg::NUM_CNT; i++) begin
                        if (n_inc[i]) begin
                            r_cnt[i] <= imix_pkg::sat_inc(r_cnt[i]);
                        end
                    end
                    r_prev_frozen <= r_in_frz;
                    r_prev_opcode <= opcode;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < imix_pkg::NUM_CNT; i++) begin
            o_m_axis_tdata[i*imix_pkg::FIELD_W +: imix_pkg::FIELD_W] =
                imix_pkg::FIELD_W'(r_cnt[i]);
        end
    end

endmodule

`default_nettype wire

@@ src/imix_checker.sv @@
// Port-level checks for the instruction-mix performance counters, bound to the top level.
// Depends on imix_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module imix_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_s_axis_tready,
    input wire logic                                o_m_axis_tvalid,
    input wire logic                                i_m_axis_tready,
    input wire logic [imix_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int W = imix_pkg::FIELD_W;

    logic [W-1:0] cycle_total;
    logic [W-1:0] retired_total;
    logic [W-1:0] stall_total;
    logic [W-1:0] rdmiss_total;
    logic [W-1:0] wrmiss_total;
    logic         out_wait;
    logic         cycle_ok;
    logic         miss_ok;

    assign cycle_total   = o_m_axis_tdata[W*int'(imix_pkg::CNT_CYCLE)   +: W];
    assign retired_total = o_m_axis_tdata[W*int'(imix_pkg::CNT_RETIRED) +: W];
    assign stall_total   = o_m_axis_tdata[W*int'(imix_pkg::CNT_STALL)   +: W];
    assign rdmiss_total  = o_m_axis_tdata[W*int'(imix_pkg::CNT_RDMISS)  +: W];
    assign wrmiss_total  = o_m_axis_tdata[W*int'(imix_pkg::CNT_WRMISS)  +: W];

    assign out_wait = o_m_axis_tvalid && !i_m_axis_tready;
    assign cycle_ok = (retired_total <= cycle_total) && (stall_total <= cycle_total);
    assign miss_ok  = (rdmiss_total <= stall_total) && (wrmiss_total <= stall_total);

    // A waiting result must hold until it is taken.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // Every counted instruction and every stall cycle is also a counted cycle.
    `ASSERT_SAME(a_cycle_bounds, i_clk, i_rst_n, o_m_axis_tvalid, cycle_ok)

    // Miss onsets are a subset of stall cycles.
    `ASSERT_SAME(a_miss_bounds, i_clk, i_rst_n, o_m_axis_tvalid, miss_ok)

    // With no result waiting, the input side is always open.
    `ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)

    // Reset empties the result stage.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind instruction_mix_perf_counters imix_checker u_imix_checker (.*);

`default_nettype wire
